### rtl/efp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape-time fractal pixel package
// Shared payload types, register indexes, field widths and fixed-point helpers.
// ----------------------------------------------------------------------------
package efp_pkg;

    localparam int PIX_W       = 12;
    localparam int COORD_W     = 32;
    localparam int STEP_W      = 31;
    localparam int RGBA_W      = 32;
    localparam int COUNT_OUT_W = 7;
    localparam int BGR_W       = 24;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int PROD_W      = 64;

    localparam int COLOR_SCALE = 65535 * 255;

    localparam logic signed [COORD_W-1:0] VIEW_LEFT_RST = -32'sd536870912;
    localparam logic signed [COORD_W-1:0] VIEW_TOP_RST  = -32'sd268435456;
    localparam logic [STEP_W-1:0]         STEP_X_RST    = 31'd1572864;
    localparam logic [STEP_W-1:0]         STEP_Y_RST    = 31'd1048576;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_VIEW_LEFT = 2'd0,
        CFG_VIEW_TOP  = 2'd1,
        CFG_STEP_X    = 2'd2,
        CFG_STEP_Y    = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_column;
        logic [PIX_W-1:0] pixel_row;
    } t_pixel_in;

    typedef struct packed {
        logic [RGBA_W-1:0]      rgba;
        logic [COUNT_OUT_W-1:0] iteration_count;
        logic                   in_set;
    } t_pixel_out;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic                      escaped;
        logic [BGR_W-1:0]          bgr;
    } t_cell;

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = (PROD_W'(1) <<< (COORD_W - 1)) - PROD_W'(1);
        lo = -(PROD_W'(1) <<< (COORD_W - 1));
        if (v > hi) begin
            return hi[COORD_W-1:0];
        end else if (v < lo) begin
            return lo[COORD_W-1:0];
        end
        return v[COORD_W-1:0];
    endfunction

endpackage

### rtl/efp_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel to point mapping
// Two-stage unit that turns a pixel index pair into the saturated point c.
// ----------------------------------------------------------------------------
module efp_map #(
    parameter int PIXEL_INDEX_BITS = 12
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_en,
    input  logic                                       i_valid,
    input  efp_pkg::t_pixel_in                         i_pixel,
    input  logic signed [efp_pkg::COORD_W-1:0]         i_view_left,
    input  logic signed [efp_pkg::COORD_W-1:0]         i_view_top,
    input  logic [efp_pkg::STEP_W-1:0]                 i_step_x,
    input  logic [efp_pkg::STEP_W-1:0]                 i_step_y,
    output logic                                       o_valid,
    output efp_pkg::t_cell                             o_state
);
    import efp_pkg::*;

    localparam int USE_BITS = (PIXEL_INDEX_BITS < PIX_W) ? PIXEL_INDEX_BITS : PIX_W;
    localparam int OFS_W    = PIX_W + STEP_W;

    logic [PIX_W-1:0]         w_col;
    logic [PIX_W-1:0]         w_row;
    logic                     r_valid;
    logic [OFS_W-1:0]         r_ofs_x;
    logic [OFS_W-1:0]         r_ofs_y;
    logic signed [PROD_W-1:0] w_sum_x;
    logic signed [PROD_W-1:0] w_sum_y;
    t_cell                    n_state;
    t_cell                    r_state;

    assign w_col = PIX_W'(i_pixel.pixel_column[USE_BITS-1:0]);
    assign w_row = PIX_W'(i_pixel.pixel_row[USE_BITS-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
            o_valid <= r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ofs_x <= OFS_W'(w_col) * OFS_W'(i_step_x);
            r_ofs_y <= OFS_W'(w_row) * OFS_W'(i_step_y);
            r_state <= n_state;
        end
    end

    assign w_sum_x = PROD_W'(i_view_left) + PROD_W'(r_ofs_x);
    assign w_sum_y = PROD_W'(i_view_top) + PROD_W'(r_ofs_y);

    always_comb begin
        n_state         = '0;
        n_state.cx      = sat32(w_sum_x);
        n_state.cy      = sat32(w_sum_y);
    end

    assign o_state = r_state;

endmodule

### rtl/efp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iteration cell
// One round of z = z*z + c with escape test and running color, two stages.
// ----------------------------------------------------------------------------
module efp_cell #(
    parameter int MAX_ITER  = 100,
    parameter int FRAC_BITS = 28,
    parameter int CNT_W     = 7,
    parameter int REM_W     = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  efp_pkg::t_cell   i_state,
    input  logic [CNT_W-1:0] i_count,
    input  logic [REM_W-1:0] i_rem,
    output logic             o_valid,
    output efp_pkg::t_cell   o_state,
    output logic [CNT_W-1:0] o_count,
    output logic [REM_W-1:0] o_rem
);
    import efp_pkg::*;

    localparam int COLOR_QUO = COLOR_SCALE / MAX_ITER;
    localparam int COLOR_REM = COLOR_SCALE % MAX_ITER;
    localparam logic [PROD_W-1:0] ESC_LIMIT = PROD_W'(1) << (2 * FRAC_BITS + 2);

    logic                     r_a_valid;
    t_cell                    r_a_state;
    logic [CNT_W-1:0]         r_a_count;
    logic [REM_W-1:0]         r_a_rem;
    logic signed [PROD_W-1:0] r_xx;
    logic signed [PROD_W-1:0] r_yy;
    logic signed [PROD_W-1:0] r_xy;
    logic signed [PROD_W-1:0] w_xx;
    logic signed [PROD_W-1:0] w_yy;
    logic signed [PROD_W-1:0] w_xy;
    logic [PROD_W-1:0]        w_mag;
    logic                     w_escape;
    logic signed [PROD_W-1:0] w_nx;
    logic signed [PROD_W-1:0] w_ny;
    logic [REM_W:0]           w_rem_sum;
    logic                     w_carry;
    t_cell                    n_state;
    logic [CNT_W-1:0]         n_count;
    logic [REM_W-1:0]         n_rem;

    assign w_xx = PROD_W'(i_state.x) * PROD_W'(i_state.x);
    assign w_yy = PROD_W'(i_state.y) * PROD_W'(i_state.y);
    assign w_xy = PROD_W'(i_state.x) * PROD_W'(i_state.y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            o_valid   <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            o_valid   <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_state <= i_state;
            r_a_count <= i_count;
            r_a_rem   <= i_rem;
            r_xx      <= w_xx;
            r_yy      <= w_yy;
            r_xy      <= w_xy;
            o_state   <= n_state;
            o_count   <= n_count;
            o_rem     <= n_rem;
        end
    end

    assign w_mag     = PROD_W'(r_xx) + PROD_W'(r_yy);
    assign w_escape  = (w_mag >= ESC_LIMIT);
    assign w_nx      = (r_xx >>> FRAC_BITS) - (r_yy >>> FRAC_BITS) + PROD_W'(r_a_state.cx);
    assign w_ny      = (r_xy >>> (FRAC_BITS - 1)) + PROD_W'(r_a_state.cy);
    assign w_rem_sum = (REM_W+1)'(r_a_rem) + (REM_W+1)'(COLOR_REM);
    assign w_carry   = (w_rem_sum >= (REM_W+1)'(MAX_ITER));

    always_comb begin
        n_state = r_a_state;
        n_count = r_a_count;
        n_rem   = r_a_rem;
        if (r_a_state.escaped || w_escape) begin
            n_state.escaped = 1'b1;
        end else begin
            n_state.x   = sat32(w_nx);
            n_state.y   = sat32(w_ny);
            n_state.bgr = r_a_state.bgr + BGR_W'(COLOR_QUO) + BGR_W'(w_carry);
            n_count     = CNT_W'(r_a_count + 1'b1);
            n_rem       = w_carry ? REM_W'(w_rem_sum - (REM_W+1)'(MAX_ITER))
                                  : REM_W'(w_rem_sum);
        end
    end

endmodule

### rtl/escape_time_fractal_pixel_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape-time fractal pixel generator
// Maps a pixel to a point, iterates it through a chain of cells, colors it.
// ----------------------------------------------------------------------------
// Usage:
// A pixel (column, row) is one transfer on the input channel; each pixel
// gives exactly one transfer on the output channel, in input order.
// The user must write the view corner and per-pixel steps through the plain
// configuration port only while no pixel is in flight; not enforced.
// Pipeline: after its input transfer, a result passes through
// 2 * MAX_ITER + 3 register stages: two of point mapping, two in each of the
// MAX_ITER iteration cells, one output register.
// A new pixel can enter every cycle while the chain is not held; the
// pipeline holds up to 2 * MAX_ITER + 3 pixels at once.
// Reset empties the pipeline and loads the default view.
// When the receiver stalls, the chain keeps advancing as long as its last
// cell stage is empty; once a finished pixel sits there, the whole chain
// and the input hold until the waiting result is transferred.
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel_top #(
    parameter int MAX_ITER         = 100,
    parameter int FRAC_BITS        = 28,
    parameter int PIXEL_INDEX_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  efp_pkg::t_pixel_in                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output efp_pkg::t_pixel_out                 o_out_data,
    input  logic                                i_cfg_we,
    input  logic [efp_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [efp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import efp_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITER + 1);
    localparam int REM_W = (MAX_ITER > 1) ? $clog2(MAX_ITER) : 1;

    logic signed [COORD_W-1:0] r_view_left;
    logic signed [COORD_W-1:0] r_view_top;
    logic [STEP_W-1:0]         r_step_x;
    logic [STEP_W-1:0]         r_step_y;

    logic                      w_adv;
    logic                      w_out_load;
    logic                      w_valid [0:MAX_ITER];
    t_cell                     w_state [0:MAX_ITER];
    logic [CNT_W-1:0]          w_count [0:MAX_ITER];
    logic [REM_W-1:0]          w_rem   [0:MAX_ITER];
    logic                      w_last_valid;
    t_cell                     w_last;
    logic [CNT_W-1:0]          w_last_count;
    logic                      r_out_valid;
    t_pixel_out                r_out_data;
    t_pixel_out                n_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_left <= VIEW_LEFT_RST;
            r_view_top  <= VIEW_TOP_RST;
            r_step_x    <= STEP_X_RST;
            r_step_y    <= STEP_Y_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_VIEW_LEFT: r_view_left <= i_cfg_data;
                CFG_VIEW_TOP:  r_view_top  <= i_cfg_data;
                CFG_STEP_X:    r_step_x    <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_Y:    r_step_y    <= i_cfg_data[STEP_W-1:0];
                default:       r_step_y    <= r_step_y;
            endcase
        end
    end

    assign w_out_load   = !r_out_valid || i_out_ready;
    assign w_last_valid = w_valid[MAX_ITER];
    assign w_last       = w_state[MAX_ITER];
    assign w_last_count = w_count[MAX_ITER];
    assign w_adv        = w_out_load || !w_last_valid;
    assign o_in_ready   = w_adv;

    efp_map #(
        .PIXEL_INDEX_BITS (PIXEL_INDEX_BITS)
    ) u_map (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_adv),
        .i_valid     (i_in_valid),
        .i_pixel     (i_in_data),
        .i_view_left (r_view_left),
        .i_view_top  (r_view_top),
        .i_step_x    (r_step_x),
        .i_step_y    (r_step_y),
        .o_valid     (w_valid[0]),
        .o_state     (w_state[0])
    );

    assign w_count[0] = '0;
    assign w_rem[0]   = '0;

    for (genvar g = 0; g < MAX_ITER; g++) begin : g_cell
        efp_cell #(
            .MAX_ITER  (MAX_ITER),
            .FRAC_BITS (FRAC_BITS),
            .CNT_W     (CNT_W),
            .REM_W     (REM_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_valid[g]),
            .i_state (w_state[g]),
            .i_count (w_count[g]),
            .i_rem   (w_rem[g]),
            .o_valid (w_valid[g+1]),
            .o_state (w_state[g+1]),
            .o_count (w_count[g+1]),
            .o_rem   (w_rem[g+1])
        );
    end

    always_comb begin
        n_out_data.iteration_count = COUNT_OUT_W'(w_last_count);
        n_out_data.in_set          = !w_last.escaped;
        if (w_last.escaped) begin
            n_out_data.rgba = {w_last.bgr[7:0], w_last.bgr[15:8], w_last.bgr[23:16], 8'hFF};
        end else begin
            n_out_data.rgba = RGBA_W'(8'hFF);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= w_last_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output valid after reset.");

    a_in_set_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.in_set
            |-> o_out_data.iteration_count == COUNT_OUT_W'(MAX_ITER))
        else $error("Point in set without full iteration count.");

    a_full_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last_valid && !w_last.escaped |-> w_last_count == CNT_W'(MAX_ITER))
        else $error("Unescaped pixel left the chain with a short count.");

    a_escape_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last_valid && w_last.escaped |-> w_last_count < CNT_W'(MAX_ITER))
        else $error("Escaped pixel carries a full count.");

    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("Input stalled while the output register is free.");

endmodule
